// File: rtl/lbps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the leaky-bucket packet shaper.
// No dependencies; every other file of the block but lbps_desc_ram imports this package.
package lbps_pkg;

	// Queue geometry and drain limit
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_RESULTS = 16;
	localparam int NSENT_W     = $clog2(MAX_RESULTS + 1);

	// Field widths
	localparam int DATA_W    = 16;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 1;
	localparam int DESC_W    = 2 * DATA_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LEAK_RATE    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_LIMIT = 1'b1;

	// Input operation codes
	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_ACCEPTED = 2'd0,
		ST_REJECTED = 2'd1,
		ST_SENT     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// Packet descriptor as held in the queue memory
	typedef struct packed {
		logic [DATA_W-1:0] id;
		logic [DATA_W-1:0] size;
	} desc_t;

	// One result transaction
	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] id;
		logic [DATA_W-1:0] size;
		logic              last;
	} result_t;

	// Controller status seen by the top level
	typedef struct packed {
		logic              busy;
		logic [CNT_W-1:0]  count;
		logic [DATA_W-1:0] occupancy;
	} ctrl_stat_t;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_EVAL  = 3'b010,
		S_FLUSH = 3'b100
	} state_t;

endpackage

// File: rtl/lbps_in_if.sv
`timescale 1ns / 1ps
// Input channel of the shaper: add or tick transactions.
// Depends on lbps_pkg for field widths.
interface lbps_in_if import lbps_pkg::*;;
	logic              valid;
	logic              ready;
	logic              func;
	logic [DATA_W-1:0] packet_id;
	logic [DATA_W-1:0] packet_size;

	modport source (output valid, func, packet_id, packet_size, input ready);
	modport sink   (input valid, func, packet_id, packet_size, output ready);
endinterface

// File: rtl/lbps_out_if.sv
`timescale 1ns / 1ps
// Result channel of the shaper.
// Depends on lbps_pkg for field widths.
interface lbps_out_if import lbps_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   out_id;
	logic [DATA_W-1:0]   out_size;
	logic                last;

	modport source (output valid, status, out_id, out_size, last, input ready);
	modport sink   (input valid, status, out_id, out_size, last, output ready);
endinterface

// File: rtl/lbps_desc_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lbps_desc_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/lbps_ctrl.sv
`timescale 1ns / 1ps
// Queue control and drain sequencer: pointers, counts, byte occupancy, tick budget.
// Depends on lbps_pkg, lbps_in_if and lbps_desc_ram.
module lbps_ctrl import lbps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	lbps_in_if.sink           pkt,
	input  logic [DATA_W-1:0] leak_rate,
	input  logic [DATA_W-1:0] bucket_limit,
	output logic              res_valid,
	input  logic              res_ready,
	output result_t           res_data,
	output ctrl_stat_t        stat
);

	state_t             state_q;
	logic [PTR_W-1:0]   head_q, tail_q, head_nxt, tail_nxt;
	logic [CNT_W-1:0]   count_q;
	logic [DATA_W-1:0]  occ_q;
	logic [DATA_W-1:0]  budget_q;
	logic [NSENT_W-1:0] nsent_q;
	desc_t              pend_q;
	logic               pend_vld_q;

	desc_t              head_desc;
	logic [DESC_W-1:0]  rd_data;
	logic               rd_en, wr_en;
	logic [PTR_W-1:0]   rd_addr;

	logic               accept, is_tick, is_add;
	logic [DATA_W:0]    occ_sum;
	logic               over_limit, full, empty;
	logic               fits, last_pick, out_free;
	logic               eval_take, eval_stop, flush_done;

	// Descriptor memory; adds only happen in idle, so a read never meets a write in flight
	lbps_desc_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (DESC_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (tail_q),
		.wr_data ({pkt.packet_id, pkt.packet_size}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign head_desc = desc_t'(rd_data);

	// Pointer wrap for any depth
	assign head_nxt = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_nxt = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// Input side
	assign pkt.ready  = (state_q == S_IDLE) && res_ready;
	assign accept     = pkt.valid && pkt.ready;
	assign is_tick    = (pkt.func == FUNC_TICK);
	assign is_add     = (pkt.func == FUNC_ADD);
	assign occ_sum    = {1'b0, occ_q} + {1'b0, pkt.packet_size};
	assign over_limit = occ_sum > {1'b0, bucket_limit};
	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty      = (count_q == '0);
	assign wr_en      = accept && is_add && !over_limit && !full;

	// Drain decisions on the head descriptor
	assign fits       = head_desc.size <= budget_q;
	assign last_pick  = (count_q == CNT_W'(1)) || (nsent_q == NSENT_W'(MAX_RESULTS - 1));
	assign out_free   = !pend_vld_q || res_ready;
	assign eval_take  = (state_q == S_EVAL) && fits && out_free;
	assign eval_stop  = (state_q == S_EVAL) && !fits && out_free;
	assign flush_done = (state_q == S_FLUSH) && res_ready;

	assign rd_en   = (accept && is_tick && !empty) || (eval_take && !last_pick);
	assign rd_addr = (state_q == S_IDLE) ? head_q : head_nxt;

	// Result selection
	always_comb begin
		res_valid = 1'b0;
		res_data  = '{status: ST_ACCEPTED, id: pkt.packet_id,
			size: pkt.packet_size, last: 1'b1};
		unique case (state_q)
			S_IDLE: begin
				res_valid = pkt.valid && !(is_tick && !empty);
				if (is_tick) begin
					res_data = '{status: ST_EMPTY, id: '0, size: '0, last: 1'b1};
				end else if (over_limit || full) begin
					res_data.status = ST_REJECTED;
				end
			end
			S_EVAL: begin
				// a held packet goes out once the next head is judged
				res_valid = pend_vld_q;
				res_data  = '{status: ST_SENT, id: pend_q.id, size: pend_q.size,
					last: !fits};
			end
			S_FLUSH: begin
				res_valid = 1'b1;
				res_data  = '{status: ST_SENT, id: pend_q.id, size: pend_q.size,
					last: 1'b1};
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			occ_q      <= '0;
			nsent_q    <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + 1'b1;
				occ_q   <= occ_sum[DATA_W-1:0];
			end
			if (accept && is_tick && !empty) begin
				nsent_q    <= '0;
				pend_vld_q <= 1'b0;
				state_q    <= S_EVAL;
			end
			if (eval_take) begin
				occ_q      <= (occ_q >= head_desc.size) ? occ_q - head_desc.size : '0;
				head_q     <= head_nxt;
				count_q    <= count_q - 1'b1;
				nsent_q    <= nsent_q + 1'b1;
				pend_vld_q <= 1'b1;
				state_q    <= last_pick ? S_FLUSH : S_EVAL;
			end
			if (eval_stop || flush_done) begin
				pend_vld_q <= 1'b0;
				state_q    <= S_IDLE;
			end
		end
	end

	// Budget and held descriptor
	always_ff @(posedge clk) begin
		if (accept && is_tick) begin
			budget_q <= leak_rate;
		end else if (eval_take) begin
			budget_q <= budget_q - head_desc.size;
		end
		if (eval_take) begin
			pend_q <= head_desc;
		end
	end

	assign stat = '{busy: (state_q != S_IDLE), count: count_q, occupancy: occ_q};

endmodule

// File: rtl/leaky_bucket_packet_shaper.sv
`timescale 1ns / 1ps
// Top level of the leaky-bucket packet shaper: config registers, result register.
// Depends on lbps_pkg, lbps_in_if, lbps_out_if and lbps_ctrl.
//
//   port    direction  contents
//   pkt     in         func, packet_id, packet_size (valid/ready)
//   res     out        status, out_id, out_size, last (valid/ready)
//   cfg_*   in         write enable, register index, 16-bit data
//
// A tick on a non-empty queue sends at most 16 packets: the tick reads the head
// descriptor, then the single read port of the descriptor RAM delivers one head
// per cycle while the result path does not stall. Reset clears pointers, counts,
// occupancy and config; the RAM is not cleared. A stalled result register holds
// the drain in place.
module leaky_bucket_packet_shaper import lbps_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	lbps_in_if.sink              pkt,
	lbps_out_if.source           res,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_wdata
);

	logic [DATA_W-1:0] leak_rate_q;
	logic [DATA_W-1:0] bucket_limit_q;
	logic              res_valid_q;
	result_t           res_q;

	logic              ctrl_res_valid;
	logic              ctrl_res_ready;
	result_t           ctrl_res;
	ctrl_stat_t        stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leak_rate_q    <= '0;
			bucket_limit_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LEAK_RATE:    leak_rate_q    <= cfg_wdata;
				REG_BUCKET_LIMIT: bucket_limit_q <= cfg_wdata;
				default:          leak_rate_q    <= leak_rate_q;
			endcase
		end
	end

	lbps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pkt          (pkt),
		.leak_rate    (leak_rate_q),
		.bucket_limit (bucket_limit_q),
		.res_valid    (ctrl_res_valid),
		.res_ready    (ctrl_res_ready),
		.res_data     (ctrl_res),
		.stat         (stat)
	);

	// Result register between controller and output channel
	assign ctrl_res_ready = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctrl_res_ready) begin
			res_valid_q <= ctrl_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_res_ready && ctrl_res_valid) begin
			res_q <= ctrl_res;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.status   = res_q.status;
	assign res.out_id   = res_q.id;
	assign res.out_size = res_q.size;
	assign res.last     = res_q.last;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_empty_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.count == '0) |-> (stat.occupancy == '0))
		else $error("bytes left in an empty queue");

	a_idle_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt.valid && pkt.ready) |-> !stat.busy)
		else $error("transaction accepted while draining");

	a_tick_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt.valid && pkt.ready && pkt.func == FUNC_TICK && stat.count != '0)
		|=> stat.busy)
		else $error("tick on a non-empty queue did not start a drain");

endmodule
